@@ rtl/core/band_level_capture_interp_assert.svh @@
// Assertion macros shared by the band level capture RTL.
`ifndef BAND_LEVEL_CAPTURE_INTERP_ASSERT_SVH
`define BAND_LEVEL_CAPTURE_INTERP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define BLCI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define BLCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define BLCI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/blci_pkg.sv @@
// Package with the constants and field widths of the band level capture block.
`default_nettype none
package blci_pkg;
  // Field widths.
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned BANDNUM_W  = 3;
  localparam int unsigned FRAC_BITS  = 12;

  // Interpolation scale and the clip level.
  localparam logic [POS_W-1:0]   FULL_SCALE = 13'd4096;
  localparam logic [LEVEL_W-1:0] CLIP_LEVEL = 8'd255;

  // Default band count.
  localparam int unsigned NUM_BANDS_DEF = 7;

  // Stream payload widths (tdata padded to whole bytes).
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 24;

  // Request kinds carried in tuser.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // Configuration port.
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_GATE_THRESHOLD = 2'd0;
endpackage
`default_nettype wire

@@ rtl/core/band_level_capture_interp.sv @@
// Band level capture with gated storage, clip flag and interpolating readback.
// Requests pass the stage-one registers, then the output register; the band store
// has one write and two reads. One request per cycle unless the output stalls.
// The interpolation multiply sits in the second stage, after the registered reads.
// Reset (synchronous, active low) clears the band counter, clip flag, threshold,
// pipeline valids and the per-band valid bits, so every band then reads as zero.
`default_nettype none
`include "band_level_capture_interp_assert.svh"
module band_level_capture_interp #(
  parameter int unsigned NUM_BANDS = blci_pkg::NUM_BANDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [0] frame_start, [10:1] adc_sample, [23:11] position
  input  wire logic [blci_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] func
  input  wire logic [blci_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] band_value, [10:8] band_number, [11] clipping, [19:12] interp_value
  output logic [blci_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [blci_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire logic [blci_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [blci_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);
  import blci_pkg::*;

  localparam int unsigned CW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int unsigned SW = FRAC_BITS + 1 + CW;
  localparam logic [CW-1:0] LAST_BAND = CW'(NUM_BANDS - 1);
  localparam int unsigned PROD_W = LEVEL_W + FRAC_BITS + 1;

  // Configuration register.
  logic [LEVEL_W-1:0] thresh_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == ADDR_GATE_THRESHOLD);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_GATE_THRESHOLD) begin
      cfg_prdata = CFG_DW'(thresh_r);
    end
  end

  // Request field unpacking.
  logic               in_func;
  logic               in_frame_start;
  logic [ADC_W-1:0]   in_adc;
  logic [POS_W-1:0]   in_pos;

  assign in_func        = in_tuser[0];
  assign in_frame_start = in_tdata[0];
  assign in_adc         = in_tdata[ADC_W:1];
  assign in_pos         = in_tdata[ADC_W+POS_W:ADC_W+1];

  // Pipeline control: stage one holds the read data, the output register the result.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Sample path: gate, band select, clip flag update.
  logic [CW-1:0]      cnt_r;
  logic               clip_r;
  logic [CW-1:0]      band_cur;
  logic [LEVEL_W-1:0] gated;
  logic               clip_nxt;
  logic [CW-1:0]      cnt_nxt;

  always_comb begin
    band_cur = in_frame_start ? '0 : cnt_r;
    gated    = in_adc[ADC_W-1:ADC_W-LEVEL_W];
    if (gated <= thresh_r) begin
      gated = '0;
    end
    clip_nxt = (in_frame_start ? 1'b0 : clip_r) || (gated == CLIP_LEVEL);
    cnt_nxt  = (band_cur >= LAST_BAND) ? '0 : band_cur + CW'(1);
  end

  // Query path: clamp the position and split it into band index and fraction.
  logic [POS_W-1:0]     pos_clamped;
  logic [SW-1:0]        scaled;
  logic [CW-1:0]        lo_addr;
  logic [CW-1:0]        hi_addr;
  logic [FRAC_BITS-1:0] frac;

  always_comb begin
    pos_clamped = (in_pos > FULL_SCALE) ? FULL_SCALE : in_pos;
    scaled      = SW'(pos_clamped) * SW'(NUM_BANDS - 1);
    lo_addr     = scaled[FRAC_BITS +: CW];
    frac        = scaled[FRAC_BITS-1:0];
    // At full scale the upper neighbor would lie past the last band.
    hi_addr     = (lo_addr >= LAST_BAND) ? LAST_BAND : lo_addr + CW'(1);
  end

  logic wr_en;
  assign wr_en = in_acc && (in_func == FUNC_SAMPLE);

  // Control state and per-band valid bits.
  logic [NUM_BANDS-1:0] band_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= '0;
      cnt_r       <= '0;
      clip_r      <= 1'b0;
      band_ok_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        thresh_r <= cfg_pwdata[LEVEL_W-1:0];
      end
      if (wr_en) begin
        cnt_r               <= cnt_nxt;
        clip_r              <= clip_nxt;
        band_ok_r[band_cur] <= 1'b1;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Band store: one write port, two registered read ports.
  logic [LEVEL_W-1:0] band_mem [NUM_BANDS];
  logic [LEVEL_W-1:0] rd_lo_r;
  logic [LEVEL_W-1:0] rd_hi_r;
  logic               rd_lo_ok_r;
  logic               rd_hi_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      band_mem[band_cur] <= gated;
    end
    if (in_acc) begin
      rd_lo_r    <= band_mem[lo_addr];
      rd_hi_r    <= band_mem[hi_addr];
      rd_lo_ok_r <= band_ok_r[lo_addr];
      rd_hi_ok_r <= band_ok_r[hi_addr];
    end
  end

  // Stage one payload.
  logic                 s1_func_r;
  logic [LEVEL_W-1:0]   s1_value_r;
  logic [BANDNUM_W-1:0] s1_band_r;
  logic                 s1_clip_r;
  logic [FRAC_BITS-1:0] s1_frac_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_func;
      s1_value_r <= (in_func == FUNC_SAMPLE) ? gated : '0;
      s1_band_r  <= (in_func == FUNC_SAMPLE) ? BANDNUM_W'(band_cur) : '0;
      s1_clip_r  <= (in_func == FUNC_SAMPLE) ? clip_nxt : clip_r;
      s1_frac_r  <= frac;
    end
  end

  // Stage two: weighted sum of the two neighbors, truncated.
  logic [LEVEL_W-1:0] lvl_lo;
  logic [LEVEL_W-1:0] lvl_hi;
  logic [PROD_W-1:0]  acc_sum;
  logic [LEVEL_W-1:0] interp;

  always_comb begin
    lvl_lo  = rd_lo_ok_r ? rd_lo_r : '0;
    lvl_hi  = rd_hi_ok_r ? rd_hi_r : '0;
    acc_sum = PROD_W'(lvl_lo) * (PROD_W'(FULL_SCALE) - PROD_W'(s1_frac_r))
            + PROD_W'(lvl_hi) * PROD_W'(s1_frac_r);
    interp  = (s1_func_r == FUNC_QUERY) ? acc_sum[FRAC_BITS +: LEVEL_W] : '0;
  end

  // Output register.
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= OUT_TDATA_W'({interp, s1_clip_r, s1_band_r, s1_value_r});
    end
  end

  assign out_tdata = out_data_r;

  // Checks.
  `BLCI_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= LAST_BAND, "band counter out of range")
  `BLCI_ASSERT(a_clip_set, clk, rst_n, (wr_en && (gated == CLIP_LEVEL)) |=> clip_r, "clip flag not set")
  `BLCI_ASSERT(a_query_keeps_cnt, clk, rst_n, (in_acc && (in_func == FUNC_QUERY)) |=> $stable(cnt_r), "query moved the band counter")
  `BLCI_ASSERT(a_stall_full, clk, rst_n, !in_tready |-> (s1_valid_r && out_valid_r), "input stalled with room in the pipeline")
endmodule
`default_nettype wire

@@ test/tb_band_level_capture_interp.sv @@
// Self-checking testbench for the band level capture and interpolation block.
import blci_pkg::*;

// One expected result, unpacked into its fields.
typedef struct packed {
  logic [LEVEL_W-1:0]   band_value;
  logic [BANDNUM_W-1:0] band_number;
  logic                 clipping;
  logic [LEVEL_W-1:0]   interp_value;
} band_reading_t;

// Tracks the band store, counter, clip flag and threshold, and checks every result.
class capture_scoreboard;
  logic [LEVEL_W-1:0] band_store [NUM_BANDS_DEF];
  int unsigned        next_band;
  bit                 clip_seen;
  logic [LEVEL_W-1:0] gate_thr;
  band_reading_t      expected_readings [$];
  int unsigned        mismatches;
  int unsigned        checked;
  int unsigned        queries;
  int unsigned        frame_starts;
  int unsigned        clip_readings;

  function new();
    foreach (band_store[i]) band_store[i] = '0;
    next_band = 0;
    clip_seen = 1'b0;
    gate_thr = '0;
    mismatches = 0;
    checked = 0;
    queries = 0;
    frame_starts = 0;
    clip_readings = 0;
  endfunction

  function void set_threshold(logic [LEVEL_W-1:0] thr);
    gate_thr = thr;
  endfunction

  function int unsigned pending();
    return expected_readings.size();
  endfunction

  // Truncated linear interpolation between neighboring bands; positions clamp to 1.0.
  function logic [LEVEL_W-1:0] interp_level(logic [POS_W-1:0] pos);
    int unsigned p;
    int unsigned s;
    int unsigned lo;
    int unsigned f;
    int unsigned acc;
    p = (pos > FULL_SCALE) ? FULL_SCALE : pos;
    s = p * (NUM_BANDS_DEF - 1);
    lo = s >> FRAC_BITS;
    f = s & ((1 << FRAC_BITS) - 1);
    // At 1.0 the last band is returned directly, with no read past the end.
    if (lo >= NUM_BANDS_DEF - 1) return band_store[NUM_BANDS_DEF - 1];
    acc = band_store[lo] * ((1 << FRAC_BITS) - f) + band_store[lo + 1] * f;
    return LEVEL_W'(acc >> FRAC_BITS);
  endfunction

  // Updates the state for an accepted request and queues the result it causes.
  function void note_request(logic func, logic fs, logic [ADC_W-1:0] adc,
                             logic [POS_W-1:0] pos);
    band_reading_t r;
    logic [LEVEL_W-1:0] v;
    r = '0;
    if (func == FUNC_SAMPLE) begin
      if (fs) begin
        next_band = 0;
        clip_seen = 1'b0;
        frame_starts++;
      end
      v = adc[ADC_W-1:2];
      if (v <= gate_thr) v = '0;
      band_store[next_band] = v;
      if (v == CLIP_LEVEL) clip_seen = 1'b1;
      r.band_value = v;
      r.band_number = BANDNUM_W'(next_band);
      next_band = (next_band == NUM_BANDS_DEF - 1) ? 0 : next_band + 1;
    end else begin
      // Queries leave the state alone and ignore the frame start bit.
      queries++;
      r.interp_value = interp_level(pos);
    end
    r.clipping = clip_seen;
    expected_readings.push_back(r);
  endfunction

  // Compares an accepted result with the oldest expectation, field by field.
  function void check_reading(logic [OUT_TDATA_W-1:0] tdata);
    band_reading_t want;
    band_reading_t got;
    got.band_value = tdata[7:0];
    got.band_number = tdata[10:8];
    got.clipping = tdata[11];
    got.interp_value = tdata[19:12];
    if (expected_readings.size() == 0) begin
      $error("out_tdata: expected no result, got %h", tdata);
      mismatches++;
      return;
    end
    want = expected_readings.pop_front();
    checked++;
    if (got.clipping === 1'b1) clip_readings++;
    if (got.band_value !== want.band_value) begin
      $error("band_value: expected %0d, got %0d", want.band_value, got.band_value);
      mismatches++;
    end
    if (got.band_number !== want.band_number) begin
      $error("band_number: expected %0d, got %0d", want.band_number, got.band_number);
      mismatches++;
    end
    if (got.clipping !== want.clipping) begin
      $error("clipping: expected %0d, got %0d", want.clipping, got.clipping);
      mismatches++;
    end
    if (got.interp_value !== want.interp_value) begin
      $error("interp_value: expected %0d, got %0d", want.interp_value, got.interp_value);
      mismatches++;
    end
  endfunction
endclass

module tb_band_level_capture_interp;
  localparam int unsigned NUM_BANDS   = NUM_BANDS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEGMENTS    = 6;
  localparam int unsigned SEG_ITEMS   = 305;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [0] frame_start, [10:1] adc_sample, [23:11] position
  logic [IN_TUSER_W-1:0]  in_tuser;   // [0] func
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] band_value, [10:8] band_number,
                                      // [11] clipping, [19:12] interp_value
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  capture_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned requests_sent;
  int unsigned cfg_mismatches;
  int unsigned thr_settings;
  int unsigned cycles;

  band_level_capture_interp #(.NUM_BANDS(NUM_BANDS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls at random according to the current idle profile.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result accepted out of reset.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reading(out_tdata);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request, idling first at random, and wait until it is accepted.
  task automatic send_request(input logic func, input logic fs,
                              input logic [ADC_W-1:0] adc, input logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {pos, adc, fs};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(func, fs, adc, pos);
    requests_sent++;
  endtask

  // Stop offering requests and wait until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the gate threshold, then read it back.
  task automatic set_gate_threshold(input logic [LEVEL_W-1:0] thr);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_GATE_THRESHOLD;
    cfg_pwdata <= CFG_DW'(thr);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_threshold(thr);
    thr_settings++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== CFG_DW'(thr)) begin
      $error("gate_threshold: expected %0d, got %0d", thr, cfg_prdata);
      cfg_mismatches++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Sample values: some at full scale, some around the threshold, the rest anywhere.
  function automatic logic [ADC_W-1:0] pick_adc();
    int t;
    case ($urandom_range(7))
      0: return ADC_W'(1020 + $urandom_range(3));
      1: begin
        t = int'(sb.gate_thr) * 4 + $urandom_range(7);
        if (t > 1023) t = 1023;
        return ADC_W'(t);
      end
      default: return ADC_W'($urandom);
    endcase
  endfunction

  // Query positions: exactly 1.0, beyond 1.0, near band boundaries, or anywhere in range.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(7))
      0: return FULL_SCALE;
      1: return POS_W'($urandom_range(4097, 8191));
      2: return POS_W'(($urandom_range(1, NUM_BANDS - 2) * 4096) / (NUM_BANDS - 1)
                       + $urandom_range(1));
      default: return POS_W'($urandom_range(4096));
    endcase
  endfunction

  // A whole frame with random content followed by queries, or now and then a broken one.
  task automatic random_frame();
    bit well_formed;
    int unsigned n_samples;
    logic fs;
    well_formed = ($urandom_range(99) < 80);
    n_samples = well_formed ? NUM_BANDS : $urandom_range(1, 10);
    for (int k = 0; k < n_samples; k++) begin
      fs = well_formed ? (k == 0) : ($urandom_range(3) == 0);
      send_request(FUNC_SAMPLE, fs, pick_adc(), POS_W'($urandom));
      if (!well_formed && $urandom_range(3) == 0)
        send_request(FUNC_QUERY, 1'($urandom), ADC_W'($urandom), pick_position());
    end
    repeat ($urandom_range(1, 4))
      send_request(FUNC_QUERY, 1'($urandom), ADC_W'($urandom), pick_position());
  endtask

  initial begin
    logic [LEVEL_W-1:0] seg_thr [SEGMENTS];
    int unsigned target;
    sb = new();
    send_idle_pct = 25;
    recv_stall_pct = 65;
    requests_sent = 0;
    cfg_mismatches = 0;
    thr_settings = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: query on the reset store, then fill one frame with edge values.
    set_gate_threshold(8'd0);
    send_request(FUNC_QUERY, 1'b0, 10'd0, 13'd0);
    send_request(FUNC_SAMPLE, 1'b1, 10'd1023, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd0, 13'd8191);
    send_request(FUNC_SAMPLE, 1'b0, 10'd3, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd512, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd1020, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd700, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd400, 13'd0);
    // Queries at both ends, clamped beyond 1.0, and between bands.
    send_request(FUNC_QUERY, 1'b0, 10'd0, 13'd0);
    send_request(FUNC_QUERY, 1'b0, 10'd0, 13'd4096);
    send_request(FUNC_QUERY, 1'b0, 10'd1023, 13'd8191);
    send_request(FUNC_QUERY, 1'b1, 10'd0, 13'd683);
    send_request(FUNC_QUERY, 1'b1, 10'd0, 13'd4095);
    // A frame start clears the clip flag; the counter then wraps past the last band.
    send_request(FUNC_SAMPLE, 1'b1, 10'd100, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'h2AA, 13'h0AAA);
    send_request(FUNC_SAMPLE, 1'b0, 10'h155, 13'h1555);
    send_request(FUNC_SAMPLE, 1'b0, 10'd1023, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd8, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd900, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd60, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd200, 13'd0);
    drain();
    // Full-scale threshold gates everything, a mid threshold checks the strict compare.
    set_gate_threshold(8'd255);
    send_request(FUNC_SAMPLE, 1'b0, 10'd1023, 13'd0);
    drain();
    set_gate_threshold(8'd100);
    send_request(FUNC_SAMPLE, 1'b0, 10'd400, 13'd0);
    send_request(FUNC_SAMPLE, 1'b0, 10'd404, 13'd0);
    send_request(FUNC_QUERY, 1'b0, 10'd0, 13'd2048);
    drain();

    // Random frames in segments, each with its own threshold and idle profile.
    seg_thr[0] = 8'd0;
    seg_thr[1] = 8'd255;
    seg_thr[2] = LEVEL_W'($urandom);
    seg_thr[3] = 8'd254;
    seg_thr[4] = LEVEL_W'($urandom_range(64));
    seg_thr[5] = LEVEL_W'($urandom);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 25;
        recv_stall_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      set_gate_threshold(seg_thr[seg]);
      target = requests_sent + SEG_ITEMS;
      while (requests_sent < target) random_frame();
      drain();
    end

    repeat (6) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    $display("Checked %0d results from %0d requests: %0d queries, %0d frame starts.",
             sb.checked, requests_sent, sb.queries, sb.frame_starts);
    $display("Used %0d threshold settings; clip flag seen set in %0d results.",
             thr_settings, sb.clip_readings);
    if (sb.mismatches == 0 && cfg_mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
